// ===== sv/frac_pkg.sv =====
// Shared types and constants for the fraction add, subtract and multiply unit.
package frac_pkg;

  localparam int OperandWidthDefault = 32;
  localparam int InDataWidth = 128;
  localparam int OutDataWidth = 128;
  localparam int ResultWidth = 64;

  localparam int OpSubBit = 0;
  localparam int OpMulBit = 1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_GCD,
    S_GCD_WAIT,
    S_Q1,
    S_Q1_WAIT,
    S_Q2,
    S_Q2_WAIT,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_MUL4,
    S_SUM,
    S_DONE
  } state_t;

endpackage

// ===== sv/frac_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module frac_div
  import frac_pkg::*;
#(
  parameter int Width = OperandWidthDefault - 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [Width-1:0] dividend,
  input  logic [Width-1:0] divisor,
  output logic             done,
  output logic [Width-1:0] quotient,
  output logic [Width-1:0] remainder
);

  localparam int CntWidth = $clog2(Width + 1);

  logic                busy;
  logic [CntWidth-1:0] cnt;
  logic [Width-1:0]    q;
  logic [Width-1:0]    r;
  logic [Width-1:0]    dv;
  logic [Width:0]      trial;

  assign trial = {r, q[Width-1]} - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CntWidth'(Width - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntWidth'(Width - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q  <= dividend;
      r  <= '0;
      dv <= divisor;
    end else if (busy) begin
      if (!trial[Width]) begin
        r <= trial[Width-1:0];
      end else begin
        r <= {r[Width-2:0], q[Width-1]};
      end
      q <= {q[Width-2:0], ~trial[Width]};
    end
  end

  assign quotient  = q;
  assign remainder = r;

endmodule

// ===== sv/frac_mul.sv =====
// Registered signed multiplier shared by all products of the unit.
module frac_mul
  import frac_pkg::*;
#(
  parameter int Width = OperandWidthDefault + 1
) (
  input  logic                    clk,
  input  logic signed [Width-1:0] a,
  input  logic signed [Width-1:0] b,
  output logic signed [2*Width-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== sv/fraction_add_sub_mul_unit_top.sv =====
// Top level of the fraction add, subtract and multiply unit.
//
//  Channel | Dir | Fields (lowest bit first)
//  s_*     | in  | tdata: first_numerator, first_denominator, second_numerator,
//          |     |        second_denominator; tuser: operation
//  m_*     | out | tdata: result_numerator, result_denominator; tuser: status
//
// Add and subtract run the Euclid steps and then both quotients on the one
// bit-serial divider, which does every modulo and quotient of the unit;
// multiply does not use the divider.
// A word is taken only while the sequencer is idle.
// The finished word waits in the output register while m_tready is low.
// Reset is synchronous and clears the sequencer and the output valid flag.
module fraction_add_sub_mul_unit_top
  import frac_pkg::*;
#(
  parameter int OPERAND_WIDTH = OperandWidthDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // first_numerator, first_denominator, second_numerator, second_denominator
  input  logic [InDataWidth-1:0]  s_tdata,
  // operation
  input  logic [1:0]              s_tuser,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // result_numerator, result_denominator
  output logic [OutDataWidth-1:0] m_tdata,
  // status
  output logic [1:0]              m_tuser
);

  localparam int W  = OPERAND_WIDTH;
  localparam int DW = OPERAND_WIDTH - 1;
  localparam int MW = OPERAND_WIDTH + 1;

  state_t state, state_next;

  logic [1:0]             op;
  logic signed [W-1:0]    n1;
  logic signed [W-1:0]    n2;
  logic [DW-1:0]          d1;
  logic [DW-1:0]          d2;
  logic [DW-1:0]          x;
  logic [DW-1:0]          y;
  logic                   larger_x;
  logic [DW-1:0]          g;
  logic [DW-1:0]          q1;
  logic [DW-1:0]          q2;
  logic [ResultWidth-1:0] t1;
  logic [ResultWidth-1:0] t2;
  logic [ResultWidth-1:0] rn;
  logic [ResultWidth-1:0] rd;
  status_t                status_r;
  logic [ResultWidth-1:0] sum;

  logic                   div_start;
  logic [DW-1:0]          div_dividend;
  logic [DW-1:0]          div_divisor;
  logic                   div_done;
  logic [DW-1:0]          div_quo;
  logic [DW-1:0]          div_rem;

  logic signed [MW-1:0]   mul_a;
  logic signed [MW-1:0]   mul_b;
  logic signed [2*MW-1:0] mul_p;
  logic [ResultWidth-1:0] prod;

  logic signed [MW-1:0]   n1_ext;
  logic signed [MW-1:0]   n2_ext;
  logic signed [MW-1:0]   n2_neg;

  logic [ResultWidth-1:0] out_rn;
  logic [ResultWidth-1:0] out_rd;
  status_t                out_status;

  assign n1_ext = {n1[W-1], n1};
  assign n2_ext = {n2[W-1], n2};
  assign n2_neg = -n2_ext;
  assign prod   = ResultWidth'(mul_p);
  assign sum    = t1 + t2;

  frac_div #(.Width(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  frac_mul #(.Width(MW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (d1 == '0 || d2 == '0) state_next = S_DONE;
        else if (op[OpMulBit]) state_next = S_MUL1;
        else state_next = S_GCD;
      end
      S_GCD: begin
        if (x == '0 || y == '0) state_next = S_Q1;
        else state_next = S_GCD_WAIT;
      end
      S_GCD_WAIT: begin
        if (div_done) state_next = S_GCD;
      end
      S_Q1:      state_next = S_Q1_WAIT;
      S_Q1_WAIT: begin
        if (div_done) state_next = S_Q2;
      end
      S_Q2:      state_next = S_Q2_WAIT;
      S_Q2_WAIT: begin
        if (div_done) state_next = S_MUL1;
      end
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_MUL3;
      S_MUL3: state_next = op[OpMulBit] ? S_DONE : S_MUL4;
      S_MUL4: state_next = S_SUM;
      S_SUM:  state_next = S_DONE;
      S_DONE: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = x;
    div_divisor  = y;
    mul_a        = n1_ext;
    mul_b        = MW'(q1);
    unique case (state)
      S_IDLE: s_tready = 1'b1;
      S_GCD: begin
        div_start = (x != '0) && (y != '0);
        if (x > y) begin
          div_dividend = x;
          div_divisor  = y;
        end else begin
          div_dividend = y;
          div_divisor  = x;
        end
      end
      S_Q1: begin
        div_start    = 1'b1;
        div_dividend = d2;
        div_divisor  = g;
      end
      S_Q2: begin
        div_start    = 1'b1;
        div_dividend = d1;
        div_divisor  = g;
      end
      S_MUL1: begin
        mul_a = n1_ext;
        mul_b = op[OpMulBit] ? n2_ext : MW'(q1);
      end
      S_MUL2: begin
        if (op[OpMulBit]) begin
          mul_a = MW'(d1);
          mul_b = MW'(d2);
        end else begin
          mul_a = op[OpSubBit] ? n2_neg : n2_ext;
          mul_b = MW'(q2);
        end
      end
      S_MUL3: begin
        mul_a = MW'(q2);
        mul_b = MW'(d2);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op <= s_tuser;
          n1 <= s_tdata[W-1:0];
          d1 <= s_tdata[32 +: DW];
          n2 <= s_tdata[63 +: W];
          d2 <= s_tdata[95 +: DW];
        end
      end
      S_CHECK: begin
        x <= d1;
        y <= d2;
        if (d1 == '0 || d2 == '0) begin
          rn       <= '0;
          rd       <= '0;
          status_r <= ST_ZERO_DEN;
        end
      end
      S_GCD: begin
        larger_x <= x > y;
        g        <= x | y;
      end
      S_GCD_WAIT: begin
        if (div_done) begin
          if (larger_x) x <= div_rem;
          else y <= div_rem;
        end
      end
      S_Q1_WAIT: begin
        if (div_done) q1 <= div_quo;
      end
      S_Q2_WAIT: begin
        if (div_done) q2 <= div_quo;
      end
      S_MUL2: begin
        if (op[OpMulBit]) rn <= prod;
        else t1 <= prod;
      end
      S_MUL3: begin
        if (op[OpMulBit]) begin
          rd       <= prod;
          status_r <= prod[ResultWidth-1] ? ST_OVERFLOW : ST_OK;
        end else begin
          t2 <= prod;
        end
      end
      S_MUL4: rd <= prod;
      S_SUM: begin
        rn <= sum;
        if ((t1[ResultWidth-1] == t2[ResultWidth-1] &&
             sum[ResultWidth-1] != t1[ResultWidth-1]) || rd[ResultWidth-1]) begin
          status_r <= ST_OVERFLOW;
        end else begin
          status_r <= ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      out_rn     <= rn;
      out_rd     <= rd;
      out_status <= status_r;
    end
  end

  assign m_tdata = {1'b0, out_rd[ResultWidth-2:0], out_rn};
  assign m_tuser = out_status;

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> div_divisor != '0)
    else $error("Divider started with a zero divisor.");

  a_zero_den_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == ST_ZERO_DEN) |-> (out_rn == '0 && out_rd == '0))
    else $error("Zero denominator word carries nonzero fields.");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == S_CHECK)
    else $error("Accepted word did not start the sequencer.");

endmodule
